// ----- sv/msp_pkg.sv -----
// Shared constants, codes and control types for the multi-stack shared pool.
`timescale 1ns / 1ps
package msp_pkg;

  localparam int NUM_STACKS_DEF = 4;
  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_W         = 32;
  localparam int SID_W          = 2;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic capture;
    logic commit;
  } msp_cmd_t;

endpackage

// ----- sv/msp_ctrl.sv -----
// Controller state machine: input handshake, commit sequencing and output valid.
`timescale 1ns / 1ps
module msp_ctrl
  import msp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output msp_cmd_t cmd
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.capture   = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!(out_valid_r && out_stall)) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_EXEC))
    else $error("capture did not move to execute");

  a_commit_not_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && out_stall))
    else $error("commit would overwrite a pending word");

endmodule

// ----- sv/msp_dp.sv -----
// Datapath: pointer registers, link and data memories, output register.
`timescale 1ns / 1ps
module msp_dp
  import msp_pkg::*;
#(
  parameter int NUM_STACKS = NUM_STACKS_DEF,
  parameter int CAPACITY   = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  msp_cmd_t                 cmd,
  input  logic                     in_cmd,
  input  logic [SID_W-1:0]         in_stack_id,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_ok,
  output logic signed [DATA_W-1:0] out_pop_value
);

  localparam int PW   = $clog2(CAPACITY + 1);
  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SW   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SIDX = (SW > SID_W) ? SW : SID_W;
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  logic [PW-1:0]     top_r [NUM_STACKS];
  logic [PW-1:0]     free_head_r;
  logic [PW-1:0]     fresh_r;

  logic [PW-1:0]     link_mem [CAPACITY];
  logic [DATA_W-1:0] data_mem [CAPACITY];
  logic [PW-1:0]     rd_link_r;
  logic [DATA_W-1:0] rd_data_r;

  logic              cmd_r;
  logic [SW-1:0]     sid_r;
  logic [DATA_W-1:0] val_r;
  logic [PW-1:0]     slot_r;
  logic              ok_r;

  logic [SIDX-1:0]   sid_ext;
  logic              in_range;
  logic [PW-1:0]     slot_nxt;
  logic              ok_nxt;
  logic              fresh_hit;
  logic [PW-1:0]     push_link;

  logic              out_ok_r;
  logic [DATA_W-1:0] out_pop_value_r;

  assign sid_ext  = SIDX'(in_stack_id);
  assign in_range = ({1'b0, sid_ext} < (SIDX+1)'(NUM_STACKS));

  always_comb begin
    slot_nxt = NIL;
    if (in_range) begin
      slot_nxt = (in_cmd == CMD_POP) ? top_r[sid_ext[SW-1:0]] : free_head_r;
    end
  end

  assign ok_nxt    = in_range && (slot_nxt != NIL);
  assign fresh_hit = (slot_r == fresh_r);
  assign push_link = fresh_hit ? (slot_r + PW'(1)) : rd_link_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r     <= in_cmd;
      sid_r     <= sid_ext[SW-1:0];
      val_r     <= in_value;
      slot_r    <= slot_nxt;
      ok_r      <= ok_nxt;
      rd_link_r <= link_mem[slot_nxt[IW-1:0]];
      rd_data_r <= data_mem[slot_nxt[IW-1:0]];
    end
    if (cmd.commit && ok_r) begin
      if (cmd_r == CMD_PUSH) begin
        link_mem[slot_r[IW-1:0]] <= top_r[sid_r];
        data_mem[slot_r[IW-1:0]] <= val_r;
      end else begin
        link_mem[slot_r[IW-1:0]] <= free_head_r;
      end
    end
    if (cmd.commit) begin
      out_ok_r        <= ok_r;
      out_pop_value_r <= (ok_r && (cmd_r == CMD_POP)) ? rd_data_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        top_r[i] <= NIL;
      end
      free_head_r <= '0;
      fresh_r     <= '0;
    end else if (cmd.commit && ok_r) begin
      if (cmd_r == CMD_PUSH) begin
        top_r[sid_r] <= slot_r;
        free_head_r  <= push_link;
        if (fresh_hit) begin
          fresh_r <= fresh_r + PW'(1);
        end
      end else begin
        top_r[sid_r] <= rd_link_r;
        free_head_r  <= slot_r;
      end
    end
  end

  assign out_ok        = out_ok_r;
  assign out_pop_value = out_pop_value_r;

  a_free_head_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= fresh_r)
    else $error("free head beyond fill count");

  a_pop_touched_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && ok_r && (cmd_r == CMD_POP)) |-> (slot_r < fresh_r))
    else $error("pop of an entry never written");

endmodule

// ----- sv/multi_stack_shared_pool.sv -----
// Top level of the multi-stack shared pool: controller plus datapath.
//
// Several LIFO stacks share one pool of CAPACITY entries kept as linked lists,
// with the unused entries on a free list. Each input word carries in_cmd
// (push or pop), in_stack_id and in_value; each accepted word yields exactly
// one result word: out_ok and out_pop_value (zero unless a pop succeeds).
// A push to a full pool, a pop from an empty stack, or a stack number at or
// above NUM_STACKS changes nothing and answers out_ok low.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// A word is captured in idle and committed in execute, registering the result.
// No new word is taken in execute: the registered read of the link memory
// must complete before the free head or top pointer is updated.
// The next input word is taken while a result still waits on a stalled output;
// a held result stalls only the commit of the following word.
// Reset (synchronous, active low) empties all stacks at once; untouched pool
// entries are tracked by a fill count, so no clearing pass is needed.
`timescale 1ns / 1ps
module multi_stack_shared_pool
  import msp_pkg::*;
#(
  parameter int NUM_STACKS = NUM_STACKS_DEF,
  parameter int CAPACITY   = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_cmd,
  input  logic [SID_W-1:0]         in_stack_id,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_ok,
  output logic signed [DATA_W-1:0] out_pop_value
);

  msp_cmd_t cmd;

  msp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  msp_dp #(
    .NUM_STACKS (NUM_STACKS),
    .CAPACITY   (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_cmd        (in_cmd),
    .in_stack_id   (in_stack_id),
    .in_value      (in_value),
    .out_ok        (out_ok),
    .out_pop_value (out_pop_value)
  );

endmodule
